// File: rtl/whp_pkg.sv
// Shared types and constants for the WAV header parser.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package whp_pkg;

   // Request and response payloads
   typedef struct packed {
      logic [7:0] file_byte;
      logic       first_byte;
      logic       last_byte;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] channel_count;
      logic [31:0] sample_rate;
      logic [15:0] bits_per_sample;
      logic [31:0] data_bytes;
      logic [31:0] data_start;
      logic [31:0] frame_total;
   } rsp_payload_type;

   // Status codes
   localparam logic [1:0] STAT_OK        = 2'd0;
   localparam logic [1:0] STAT_NOT_RIFF  = 2'd1;
   localparam logic [1:0] STAT_NOT_WAVE  = 2'd2;
   localparam logic [1:0] STAT_TRUNCATED = 2'd3;

   // Chunk tags, first byte in the top lane
   localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
   localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
   localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
   localparam logic [31:0] TAG_DATA = 32'h6461_7461;

   // fmt body layout
   localparam logic [31:0] FMT_BODY      = 32'd16;
   localparam logic [3:0]  FMT_CHAN_LO   = 4'd2;
   localparam logic [3:0]  FMT_CHAN_HI   = 4'd3;
   localparam logic [3:0]  FMT_RATE_B0   = 4'd4;
   localparam logic [3:0]  FMT_RATE_B1   = 4'd5;
   localparam logic [3:0]  FMT_RATE_B2   = 4'd6;
   localparam logic [3:0]  FMT_RATE_B3   = 4'd7;
   localparam logic [3:0]  FMT_DEPTH_LO  = 4'd14;
   localparam logic [3:0]  FMT_DEPTH_HI  = 4'd15;
   localparam logic [3:0]  FMT_LAST      = 4'd15;
   localparam logic [1:0]  WORD_LAST     = 2'd3;

   // Frame size: channels (16 bits) times bytes per sample (13 bits)
   localparam int FRAME_W   = 29;
   localparam int DIV_STEPS = 32;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   typedef enum logic [2:0] {
      PH_RIFF,
      PH_RSIZE,
      PH_WAVE,
      PH_CTAG,
      PH_CSIZE,
      PH_FMT,
      PH_SKIP,
      PH_DONE
   } phase_type;

   // Controller to datapath
   typedef struct packed {
      logic       restart;
      logic       advance;
      logic       tag_en;
      logic       chunk_clear;
      logic       chunk_en;
      logic       skip_load_chunk;
      logic       skip_load_fmt;
      logic       skip_dec;
      logic       fmt_en;
      logic [3:0] idx;
      logic       emit;
      logic [1:0] status;
   } ctrl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic next_is_riff;
      logic next_is_wave;
      logic tag_is_fmt;
      logic tag_is_data;
      logic chunk_next_zero;
      logic chunk_over_body;
      logic skip_le_one;
   } dp_stat_type;

endpackage

`default_nettype wire

// File: rtl/whp_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on whp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module whp_div
   import whp_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [31:0]        dividend,
   input  wire logic [FRAME_W-1:0] divisor,
   output logic                    busy,
   output logic                    done,
   output logic [31:0]             quotient
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [FRAME_W-1:0]   rem_ff, rem_in;
   logic [FRAME_W-1:0]   dvs_ff, dvs_in;
   logic [31:0]          quo_ff, quo_in;
   logic [FRAME_W:0]     trial;
   logic [FRAME_W:0]     diff;
   logic                 ge;

   assign trial = {rem_ff, quo_ff[31]};
   assign ge    = trial >= {1'b0, dvs_ff};
   assign diff  = trial - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         dvs_in  = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in = ge ? diff[FRAME_W-1:0] : trial[FRAME_W-1:0];
         quo_in = {quo_ff[30:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign busy     = busy_ff | done_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

// File: rtl/whp_ctrl.sv
// Parse controller: phase and field-byte sequencing, command generation.
// Depends on whp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module whp_ctrl
   import whp_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_accept,
   input  wire logic         first_byte,
   input  wire logic         last_byte,
   input  wire dp_stat_type  stat,
   output ctrl_cmd_type      cmd
);

   phase_type  phase_ff, phase_in, ph, ph_main;
   logic [3:0] idx_ff, idx_in, idx;
   logic       active;
   logic       word_end;

   // a first byte restarts the parse before it is consumed
   assign ph       = first_byte ? PH_RIFF : phase_ff;
   assign idx      = first_byte ? 4'd0 : idx_ff;
   assign active   = req_accept && (ph != PH_DONE);
   assign word_end = idx[1:0] == WORD_LAST;

   // next state
   always_comb begin
      ph_main = ph;
      idx_in  = req_accept ? idx : idx_ff;
      if (active) begin
         case (ph)
            PH_RIFF: begin
               idx_in = word_end ? 4'd0 : idx + 1'b1;
               if (word_end) ph_main = stat.next_is_riff ? PH_RSIZE : PH_DONE;
            end
            PH_RSIZE: begin
               idx_in = word_end ? 4'd0 : idx + 1'b1;
               if (word_end) ph_main = PH_WAVE;
            end
            PH_WAVE: begin
               idx_in = word_end ? 4'd0 : idx + 1'b1;
               if (word_end) ph_main = stat.next_is_wave ? PH_CTAG : PH_DONE;
            end
            PH_CTAG: begin
               idx_in = word_end ? 4'd0 : idx + 1'b1;
               if (word_end) ph_main = PH_CSIZE;
            end
            PH_CSIZE: begin
               idx_in = word_end ? 4'd0 : idx + 1'b1;
               if (word_end) begin
                  if (stat.tag_is_fmt)           ph_main = PH_FMT;
                  else if (stat.tag_is_data)     ph_main = PH_DONE;
                  else if (stat.chunk_next_zero) ph_main = PH_CTAG;
                  else                           ph_main = PH_SKIP;
               end
            end
            PH_FMT: begin
               idx_in = idx + 1'b1;
               if (idx == FMT_LAST) ph_main = stat.chunk_over_body ? PH_SKIP : PH_CTAG;
            end
            PH_SKIP: begin
               if (stat.skip_le_one) ph_main = PH_CTAG;
            end
            default: ph_main = PH_DONE;
         endcase
      end
      phase_in = req_accept ? ph_main : phase_ff;
      if (active && last_byte) phase_in = PH_DONE;
   end

   // commands
   always_comb begin
      cmd         = '0;
      cmd.idx     = idx;
      cmd.restart = req_accept && first_byte;
      cmd.advance = active;
      if (active) begin
         case (ph)
            PH_RIFF: begin
               cmd.tag_en = 1'b1;
               if (word_end && !stat.next_is_riff) begin
                  cmd.emit   = 1'b1;
                  cmd.status = STAT_NOT_RIFF;
               end
            end
            PH_RSIZE: cmd.tag_en = 1'b0;
            PH_WAVE: begin
               cmd.tag_en = 1'b1;
               if (word_end && !stat.next_is_wave) begin
                  cmd.emit   = 1'b1;
                  cmd.status = STAT_NOT_WAVE;
               end
            end
            PH_CTAG: begin
               cmd.tag_en      = 1'b1;
               cmd.chunk_clear = word_end;
            end
            PH_CSIZE: begin
               cmd.chunk_en = 1'b1;
               if (word_end && !stat.tag_is_fmt) begin
                  if (stat.tag_is_data) begin
                     cmd.emit   = 1'b1;
                     cmd.status = STAT_OK;
                  end else begin
                     cmd.skip_load_chunk = !stat.chunk_next_zero;
                  end
               end
            end
            PH_FMT: begin
               cmd.fmt_en        = 1'b1;
               cmd.skip_load_fmt = (idx == FMT_LAST) && stat.chunk_over_body;
            end
            PH_SKIP: cmd.skip_dec = 1'b1;
            default: cmd.advance = 1'b1;
         endcase
         // final byte without an earlier result
         if (!cmd.emit && last_byte) begin
            cmd.emit   = 1'b1;
            cmd.status = STAT_TRUNCATED;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_RIFF;
         idx_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         idx_ff   <= idx_in;
      end
   end

   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DONE) && !(req_accept && first_byte) |=> phase_ff == PH_DONE)
      else $error("parse left finished state without a restart");

   a_emit_finishes: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> phase_ff == PH_DONE)
      else $error("result issued but parse not finished");

   a_emit_needs_accept: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> req_accept)
      else $error("result issued without an accepted request");

endmodule

`default_nettype wire

// File: rtl/whp_dpath.sv
// Parse datapath: tag and size assembly, skip counter, held fmt fields.
// Depends on whp_pkg; driven by whp_ctrl commands.
`timescale 1ns / 1ps
`default_nettype none

module whp_dpath
   import whp_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire ctrl_cmd_type  cmd,
   input  wire logic [7:0]    file_byte,
   output dp_stat_type        stat,
   output rsp_payload_type    stage,
   output logic [FRAME_W-1:0] divisor,
   output logic               divisor_nz
);

   logic [31:0] tag_ff, tag_in, tag_next;
   logic [31:0] chunk_ff, chunk_in, chunk_next;
   logic [31:0] skip_ff, skip_in;
   logic [31:0] pos_ff, pos_in, pos_plus;
   logic [15:0] chan_ff, chan_in;
   logic [31:0] rate_ff, rate_in;
   logic [15:0] depth_ff, depth_in;
   logic        ok;

   assign tag_next = {tag_ff[23:0], file_byte};
   assign pos_plus = pos_ff + 32'd1;

   always_comb begin
      chunk_next = chunk_ff;
      case (cmd.idx[1:0])
         2'd0:    chunk_next[7:0]   = chunk_ff[7:0]   | file_byte;
         2'd1:    chunk_next[15:8]  = chunk_ff[15:8]  | file_byte;
         2'd2:    chunk_next[23:16] = chunk_ff[23:16] | file_byte;
         default: chunk_next[31:24] = chunk_ff[31:24] | file_byte;
      endcase
   end

   always_comb begin
      tag_in   = cmd.tag_en ? tag_next : tag_ff;
      chunk_in = chunk_ff;
      if (cmd.chunk_clear)   chunk_in = '0;
      else if (cmd.chunk_en) chunk_in = chunk_next;

      skip_in = skip_ff;
      if (cmd.skip_load_chunk)                 skip_in = chunk_next;
      else if (cmd.skip_load_fmt)              skip_in = chunk_ff - FMT_BODY;
      else if (cmd.skip_dec && skip_ff != '0)  skip_in = skip_ff - 32'd1;

      pos_in = pos_ff;
      if (cmd.advance) pos_in = cmd.restart ? 32'd1 : pos_plus;

      chan_in  = cmd.restart ? '0 : chan_ff;
      rate_in  = cmd.restart ? '0 : rate_ff;
      depth_in = cmd.restart ? '0 : depth_ff;
      if (cmd.fmt_en) begin
         case (cmd.idx)
            FMT_CHAN_LO:  chan_in[7:0]    = file_byte;
            FMT_CHAN_HI:  chan_in[15:8]   = file_byte;
            FMT_RATE_B0:  rate_in[7:0]    = file_byte;
            FMT_RATE_B1:  rate_in[15:8]   = file_byte;
            FMT_RATE_B2:  rate_in[23:16]  = file_byte;
            FMT_RATE_B3:  rate_in[31:24]  = file_byte;
            FMT_DEPTH_LO: depth_in[7:0]   = file_byte;
            FMT_DEPTH_HI: depth_in[15:8]  = file_byte;
            default:      chan_in         = chan_in;
         endcase
      end
   end

   always_comb begin
      stat.next_is_riff    = tag_next == TAG_RIFF;
      stat.next_is_wave    = tag_next == TAG_WAVE;
      stat.tag_is_fmt      = tag_ff == TAG_FMT;
      stat.tag_is_data     = tag_ff == TAG_DATA;
      stat.chunk_next_zero = chunk_next == '0;
      stat.chunk_over_body = chunk_ff > FMT_BODY;
      stat.skip_le_one     = skip_ff <= 32'd1;
   end

   // result fields, held values as left by this byte
   assign ok = cmd.status == STAT_OK;
   always_comb begin
      stage.status          = cmd.status;
      stage.channel_count   = chan_in;
      stage.sample_rate     = rate_in;
      stage.bits_per_sample = depth_in;
      stage.data_bytes      = ok ? chunk_next : '0;
      stage.data_start      = ok ? pos_plus : '0;
      stage.frame_total     = '0;
   end

   // bytes per frame: 16 x 13 bit product, registered inside the divider
   assign divisor    = FRAME_W'(chan_in) * FRAME_W'(depth_in[15:3]);
   assign divisor_nz = (chan_in != '0) && (depth_in[15:3] != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff   <= '0;
         chunk_ff <= '0;
         skip_ff  <= '0;
         pos_ff   <= '0;
         chan_ff  <= '0;
         rate_ff  <= '0;
         depth_ff <= '0;
      end else begin
         tag_ff   <= tag_in;
         chunk_ff <= chunk_in;
         skip_ff  <= skip_in;
         pos_ff   <= pos_in;
         chan_ff  <= chan_in;
         rate_ff  <= rate_in;
         depth_ff <= depth_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/wav_header_parser.sv
// WAV header parser top level: handshakes, response register, divider.
// Depends on whp_pkg, whp_ctrl, whp_dpath, whp_div.
//
//  Channel  Ports                         Direction  Contents
//  req      req_valid/req_ready/req_payload  in       one file byte, first/last marks
//  rsp      rsp_valid/rsp_ready/rsp_payload  out      status, fmt fields, data chunk info
//
// Cycles: one byte per cycle while parsing and not stalled. A byte that yields a result
//   with status ok and a nonzero frame size starts the 32-step divider;
//   requests are held off until frame_total is known.
// Other results go to the response register the cycle after the byte.
// Reset: synchronous, active high; parse restarts at the RIFF tag.
// Stalls: req_ready drops while the divider runs or while a response
//   waits in the output register and rsp_ready is low.
`timescale 1ns / 1ps
`default_nettype none

module wav_header_parser
   import whp_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire req_payload_type req_payload,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output rsp_payload_type      rsp_payload
);

   ctrl_cmd_type       cmd;
   dp_stat_type        stat;
   rsp_payload_type    stage;
   rsp_payload_type    rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [FRAME_W-1:0] divisor;
   logic               divisor_nz;
   logic               req_accept;
   logic               div_start, div_busy, div_done;
   logic [31:0]        div_quotient;

   // hold input while dividing or while the response slot stays full
   assign req_ready  = !div_busy && (!rsp_valid_ff || rsp_ready);
   assign req_accept = req_valid && req_ready;

   whp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .first_byte (req_payload.first_byte),
      .last_byte  (req_payload.last_byte),
      .stat       (stat),
      .cmd        (cmd)
   );

   whp_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .file_byte  (req_payload.file_byte),
      .stat       (stat),
      .stage      (stage),
      .divisor    (divisor),
      .divisor_nz (divisor_nz)
   );

   // frame count only for good headers with a nonzero frame size
   assign div_start = cmd.emit && (cmd.status == STAT_OK) && divisor_nz;

   whp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (stage.data_bytes),
      .divisor  (divisor),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // response register
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (div_done) begin
         rsp_in.frame_total = div_quotient;
         rsp_valid_in       = 1'b1;
      end
      if (cmd.emit) begin
         rsp_in       = stage;
         rsp_valid_in = !div_start;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_div_delivers: assert property (@(posedge clock) disable iff (reset)
      div_done |=> rsp_valid)
      else $error("divider finished but no response presented");

   a_single_byte_file: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_payload.first_byte && req_payload.last_byte |=> rsp_valid)
      else $error("one-byte file gave no truncation response");

   a_no_emit_in_divide: assert property (@(posedge clock) disable iff (reset)
      div_busy |-> !cmd.emit)
      else $error("new result while divider busy");

endmodule

`default_nettype wire

// File: test/wav_header_parser_test.sv
// Self-checking testbench for wav_header_parser: byte-serial WAV header parsing.
// Depends on whp_pkg and the wav_header_parser RTL; needs no other files.
`timescale 1ns / 1ps

module wav_header_parser_test;
   import whp_pkg::*;

   // Chunk tags the parser must walk past without interpreting
   localparam logic [31:0] LIST_TAG = 32'h4C49_5354;
   localparam logic [31:0] JUNK_TAG = 32'h6A75_6E6B;

   // Random phase stops once it has parsed this many bytes and predicted
   // this many headers
   localparam int RANDOM_BYTES   = 900;
   localparam int RANDOM_HEADERS = 48;

   // Cycles to keep watching the response side once nothing is pending;
   // covers the frame divider with margin
   localparam int DRAIN_CYCLES = 64;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   rsp_payload_type rsp_payload;

   wav_header_parser u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Header predictor: own copy of the parse state, advanced once per
   // accepted request. Every predicted header goes to expected_headers.
   // ------------------------------------------------------------------
   phase_type   hdr_phase;
   logic [31:0] byte_pos;
   logic [4:0]  field_idx;
   logic [31:0] tag_acc;
   logic [31:0] chunk_len;
   logic [31:0] skip_left;
   logic [15:0] fmt_channels;
   logic [31:0] fmt_rate;
   logic [15:0] fmt_depth;
   logic        hdr_done;

   rsp_payload_type expected_headers[$];
   int              headers_predicted = 0;
   int              bytes_parsed = 0;
   int              mismatch_count = 0;

   function automatic void clear_parse();
      hdr_phase    = PH_RIFF;
      byte_pos     = '0;
      field_idx    = '0;
      tag_acc      = '0;
      chunk_len    = '0;
      skip_left    = '0;
      fmt_channels = '0;
      fmt_rate     = '0;
      fmt_depth    = '0;
      hdr_done     = 1'b0;
   endfunction

   // Queue one header and close the parse. Frame size is channels times
   // whole bytes per sample; a zero frame size gives a zero frame count.
   function automatic void post_header(input logic [1:0] st, input logic [31:0] nbytes,
                                       input logic [31:0] start);
      rsp_payload_type hdr;
      logic [31:0]     frame;
      frame               = {16'd0, fmt_channels} * {19'd0, fmt_depth[15:3]};
      hdr.status          = st;
      hdr.channel_count   = fmt_channels;
      hdr.sample_rate     = fmt_rate;
      hdr.bits_per_sample = fmt_depth;
      hdr.data_bytes      = nbytes;
      hdr.data_start      = start;
      hdr.frame_total     = (st == STAT_OK && frame != 0) ? nbytes / frame : 32'd0;
      expected_headers.push_back(hdr);
      headers_predicted++;
      hdr_done  = 1'b1;
      hdr_phase = PH_DONE;
   endfunction

   function automatic void parse_byte(input req_payload_type p);
      logic [31:0] pos;
      logic [3:0]  fi;
      logic        posted;
      posted = 1'b0;
      if (p.first_byte)
         clear_parse();
      if (hdr_done)
         return;
      bytes_parsed++;
      pos      = byte_pos;
      byte_pos = pos + 32'd1;
      case (hdr_phase)
         PH_RIFF, PH_WAVE, PH_CTAG: begin
            tag_acc   = {tag_acc[23:0], p.file_byte};
            field_idx = field_idx + 5'd1;
            if (field_idx >= 5'd4) begin
               field_idx = '0;
               if (hdr_phase == PH_RIFF) begin
                  if (tag_acc != TAG_RIFF) begin
                     post_header(STAT_NOT_RIFF, 32'd0, 32'd0);
                     posted = 1'b1;
                  end else begin
                     hdr_phase = PH_RSIZE;
                  end
               end else if (hdr_phase == PH_WAVE) begin
                  if (tag_acc != TAG_WAVE) begin
                     post_header(STAT_NOT_WAVE, 32'd0, 32'd0);
                     posted = 1'b1;
                  end else begin
                     hdr_phase = PH_CTAG;
                  end
               end else begin
                  chunk_len = '0;
                  hdr_phase = PH_CSIZE;
               end
            end
         end
         PH_RSIZE: begin
            field_idx = field_idx + 5'd1;
            if (field_idx >= 5'd4) begin
               field_idx = '0;
               hdr_phase = PH_WAVE;
            end
         end
         PH_CSIZE: begin
            // size arrives little-endian
            chunk_len = chunk_len | ({24'd0, p.file_byte} << (8 * field_idx[1:0]));
            field_idx = field_idx + 5'd1;
            if (field_idx >= 5'd4) begin
               field_idx = '0;
               if (tag_acc == TAG_FMT) begin
                  hdr_phase = PH_FMT;
               end else if (tag_acc == TAG_DATA) begin
                  post_header(STAT_OK, chunk_len, pos + 32'd1);
                  posted = 1'b1;
               end else if (chunk_len == 0) begin
                  hdr_phase = PH_CTAG;
               end else begin
                  skip_left = chunk_len;
                  hdr_phase = PH_SKIP;
               end
            end
         end
         PH_FMT: begin
            fi = field_idx[3:0];
            case (fi)
               FMT_CHAN_LO:  fmt_channels[7:0]  = p.file_byte;
               FMT_CHAN_HI:  fmt_channels[15:8] = p.file_byte;
               FMT_RATE_B0:  fmt_rate[7:0]      = p.file_byte;
               FMT_RATE_B1:  fmt_rate[15:8]     = p.file_byte;
               FMT_RATE_B2:  fmt_rate[23:16]    = p.file_byte;
               FMT_RATE_B3:  fmt_rate[31:24]    = p.file_byte;
               FMT_DEPTH_LO: fmt_depth[7:0]     = p.file_byte;
               FMT_DEPTH_HI: fmt_depth[15:8]    = p.file_byte;
               default: ;
            endcase
            field_idx = {1'b0, fi} + 5'd1;
            // short fmt chunks still consume a full 16-byte body
            if (field_idx >= FMT_BODY[4:0]) begin
               field_idx = '0;
               if (chunk_len > FMT_BODY) begin
                  skip_left = chunk_len - FMT_BODY;
                  hdr_phase = PH_SKIP;
               end else begin
                  hdr_phase = PH_CTAG;
               end
            end
         end
         PH_SKIP: begin
            if (skip_left > 0)
               skip_left = skip_left - 32'd1;
            if (skip_left == 0)
               hdr_phase = PH_CTAG;
         end
         default: begin
            hdr_done  = 1'b1;
            hdr_phase = PH_DONE;
         end
      endcase
      // a last byte that produced nothing itself flags a truncated file
      if (!posted && p.last_byte && !hdr_done)
         post_header(STAT_TRUNCATED, 32'd0, 32'd0);
   endfunction

   // ------------------------------------------------------------------
   // Request side: bursts of random length separated by random gaps.
   // Valid is only lowered at the start of a gap, never between two
   // back-to-back requests.
   // ------------------------------------------------------------------
   int burst_left = 0;

   task automatic send_byte(input logic [7:0] b, input logic is_first, input logic is_last);
      req_payload_type p;
      int              gap;
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         burst_left = $urandom_range(1, 40);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      p.file_byte  = b;
      p.first_byte = is_first;
      p.last_byte  = is_last;
      req_valid   <= 1'b1;
      req_payload <= p;
      do @(posedge clock); while (req_ready !== 1'b1);
      parse_byte(p);
      burst_left--;
   endtask

   // File image under construction, sent with send_image
   logic [7:0] file_img[$];
   int         data_hdr_end;

   task automatic put_le(input logic [31:0] v, input int n);
      int i;
      for (i = 0; i < n; i++)
         file_img.push_back(v[8*i +: 8]);
   endtask

   task automatic put_tag(input logic [31:0] t);
      file_img.push_back(t[31:24]);
      file_img.push_back(t[23:16]);
      file_img.push_back(t[15:8]);
      file_img.push_back(t[7:0]);
   endtask

   task automatic put_random(input int n);
      repeat (n) file_img.push_back($urandom_range(0, 255));
   endtask

   task automatic put_chunk_head(input logic [31:0] t, input logic [31:0] size);
      put_tag(t);
      put_le(size, 4);
   endtask

   // fmt header plus the 16-byte body; bytes past 16 are up to the caller
   task automatic put_fmt(input logic [31:0] size, input logic [15:0] ch,
                          input logic [31:0] rate, input logic [15:0] depth);
      put_chunk_head(TAG_FMT, size);
      put_random(2);          // audio format
      put_le({16'd0, ch}, 2);
      put_le(rate, 4);
      put_random(6);          // byte rate, block align
      put_le({16'd0, depth}, 2);
   endtask

   task automatic start_wave();
      file_img.delete();
      put_tag(TAG_RIFF);
      put_random(4);
      put_tag(TAG_WAVE);
   endtask

   task automatic put_data_head(input logic [31:0] nbytes);
      put_chunk_head(TAG_DATA, nbytes);
      data_hdr_end = file_img.size();
   endtask

   // Send the first n bytes of the image, marks on the end bytes
   task automatic send_image(input int n, input logic mark_first, input logic mark_last);
      int i;
      for (i = 0; i < n; i++)
         send_byte(file_img[i], mark_first && i == 0, mark_last && i == n - 1);
   endtask

   task automatic send_wave(input logic [15:0] ch, input logic [31:0] rate,
                            input logic [15:0] depth, input logic [31:0] nbytes);
      start_wave();
      put_fmt(32'd16, ch, rate, depth);
      put_data_head(nbytes);
      put_random(2);
      send_image(file_img.size(), 1'b1, 1'b0);
   endtask

   // ------------------------------------------------------------------
   // Response side: ready follows a 16-bit pattern that is redrawn
   // each time it has been played through; some periods never stall, some stall hard.
   // ------------------------------------------------------------------
   logic [15:0] stall_pattern = 16'hFFFF;
   int          stall_phase = 0;

   always @(posedge clock) begin
      if (stall_phase == 0) begin
         case ($urandom_range(0, 4))
            0, 1:    stall_pattern <= 16'hFFFF;
            2:       stall_pattern <= $urandom_range(0, 16'hFFFF);
            3:       stall_pattern <= 16'h00FF;
            default: stall_pattern <= 16'hAAAA;
         endcase
      end
      rsp_ready   <= stall_pattern[stall_phase];
      stall_phase <= (stall_phase + 1) % 16;
   end

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatch_count++;
      end
   endtask

   // Each accepted response is matched against the oldest predicted header
   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (expected_headers.size() == 0) begin
            $error("response with no header pending: %0h", rsp_payload);
            mismatch_count++;
         end else begin
            want = expected_headers.pop_front();
            compare_field("status", {30'd0, want.status}, {30'd0, rsp_payload.status});
            compare_field("channel_count", {16'd0, want.channel_count},
                          {16'd0, rsp_payload.channel_count});
            compare_field("sample_rate", want.sample_rate, rsp_payload.sample_rate);
            compare_field("bits_per_sample", {16'd0, want.bits_per_sample},
                          {16'd0, rsp_payload.bits_per_sample});
            compare_field("data_bytes", want.data_bytes, rsp_payload.data_bytes);
            compare_field("data_start", want.data_start, rsp_payload.data_start);
            compare_field("frame_total", want.frame_total, rsp_payload.frame_total);
         end
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // First file after reset carries no first_byte mark; trailing audio
   // bytes, the last one marked, are ignored once the data header is seen
   task automatic test_no_restart_mark();
      start_wave();
      put_fmt(32'd16, 16'd2, 32'd44100, 16'd16);
      put_data_head(32'd4000);
      put_random(3);
      send_image(file_img.size(), 1'b0, 1'b1);
   endtask

   task automatic test_tag_errors();
      // bad RIFF tag on the byte that also carries the last mark
      file_img.delete();
      put_tag(TAG_RIFF ^ 32'h0000_0001);
      send_image(4, 1'b1, 1'b1);
      // bad first tag byte, then ignored bytes up to a last mark
      file_img.delete();
      put_tag(TAG_RIFF ^ 32'h8000_0000);
      put_random(3);
      send_image(7, 1'b1, 1'b1);
      // all-zero and all-one tags
      file_img.delete();
      put_tag(32'h0000_0000);
      put_tag(32'hFFFF_FFFF);
      send_image(4, 1'b1, 1'b0);
      send_image(8, 1'b0, 1'b0);
      file_img.delete();
      put_tag(32'hFFFF_FFFF);
      send_image(4, 1'b1, 1'b0);
      // bad WAVE tag
      start_wave();
      file_img[11] ^= 8'h01;
      put_random(2);
      send_image(file_img.size(), 1'b1, 1'b0);
   endtask

   task automatic test_fmt_extremes();
      send_wave(16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
      send_wave(16'd0, 32'd0, 16'd0, 32'd123);             // no channels
      send_wave(16'd1, 32'd8000, 16'd8, 32'd0);            // empty data
      send_wave(16'd2, 32'd48000, 16'd7, 32'd1000);        // under a byte per sample
      send_wave(16'd3, 32'd1, 16'd12, 32'd10);             // partial byte dropped
      send_wave(16'd1, 32'd22050, 16'd8, 32'hFFFF_FFFF);
   endtask

   task automatic test_chunk_walk();
      // odd-size and empty foreign chunks, then fmt with extra bytes
      start_wave();
      put_chunk_head(LIST_TAG, 32'd3);
      put_random(3);
      put_chunk_head(JUNK_TAG, 32'd0);
      put_fmt(32'd18, 16'd2, 32'd22050, 16'd24);
      put_random(2);
      put_data_head(32'd600);
      send_image(file_img.size(), 1'b1, 1'b1);
      // short fmt chunk: a full body is still consumed
      start_wave();
      put_fmt(32'd4, 16'd1, 32'd8000, 16'd8);
      put_data_head(32'd77);
      send_image(file_img.size(), 1'b1, 1'b0);
      // second fmt chunk overrides the first
      start_wave();
      put_fmt(32'd16, 16'd1, 32'd8000, 16'd8);
      put_fmt(32'd40, 16'd6, 32'd96000, 16'd32);
      put_random(24);
      put_data_head(32'd9600);
      send_image(file_img.size(), 1'b1, 1'b0);
      // data before any fmt
      start_wave();
      put_data_head(32'h0000_1234);
      send_image(file_img.size(), 1'b1, 1'b0);
   endtask

   task automatic test_truncation();
      // one-byte file
      file_img.delete();
      put_random(1);
      send_image(1, 1'b1, 1'b1);
      // ends inside the RIFF size
      start_wave();
      send_image(6, 1'b1, 1'b1);
      // ends inside the fmt body, fields partly held
      start_wave();
      put_fmt(32'd16, 16'd2, 32'd32000, 16'd16);
      send_image(file_img.size() - 3, 1'b1, 1'b1);
      // ends while skipping a huge chunk
      start_wave();
      put_fmt(32'd16, 16'd4, 32'd11025, 16'd8);
      put_chunk_head(JUNK_TAG, 32'hFFFF_FFFF);
      put_random(5);
      send_image(file_img.size(), 1'b1, 1'b1);
      // ends while skipping the tail of a huge fmt chunk
      start_wave();
      put_fmt(32'hFFFF_FFFF, 16'd2, 32'd16000, 16'd16);
      put_random(4);
      send_image(file_img.size(), 1'b1, 1'b1);
      // last mark on the final data size byte: only the ok header
      start_wave();
      put_fmt(32'd16, 16'd2, 32'd44100, 16'd24);
      put_data_head(32'd999);
      send_image(file_img.size(), 1'b1, 1'b1);
      // abandoned file, restarted by the next first_byte
      start_wave();
      put_fmt(32'd16, 16'd8, 32'd192000, 16'd32);
      send_image(20, 1'b1, 1'b0);
      send_wave(16'd2, 32'd44100, 16'd16, 32'd8192);
   endtask

   function automatic logic [15:0] pick_channels();
      case ($urandom_range(0, 5))
         0:       return 16'd1;
         1:       return 16'd2;
         2:       return $urandom_range(0, 8);
         3:       return $urandom_range(0, 16'hFFFF);
         4:       return 16'd0;
         default: return 16'hFFFF;
      endcase
   endfunction

   function automatic logic [15:0] pick_depth();
      case ($urandom_range(0, 5))
         0:       return 16'd8;
         1:       return 16'd16;
         2:       return 16'd24;
         3:       return 16'd32;
         4:       return $urandom_range(0, 40);
         default: return $urandom_range(0, 16'hFFFF);
      endcase
   endfunction

   task automatic put_random_fmt();
      logic [31:0] size;
      logic [31:0] rate;
      case ($urandom_range(0, 5))
         0, 1, 2: size = 32'd16;
         3:       size = $urandom_range(0, 15);
         4:       size = 32'd18;
         default: size = 32'd16 + $urandom_range(1, 9);
      endcase
      case ($urandom_range(0, 2))
         0:       rate = 32'd44100;
         1:       rate = 32'd48000;
         default: rate = $urandom;
      endcase
      put_fmt(size, pick_channels(), rate, pick_depth());
      if (size > 16)
         put_random(size - 16);
   endtask

   // Well-formed file with random chunk layout and field values
   task automatic build_random_wave();
      int          len;
      logic [31:0] nbytes;
      start_wave();
      repeat ($urandom_range(0, 2)) begin
         len = $urandom_range(0, 9);
         put_chunk_head($urandom, len);
         put_random(len);
      end
      if ($urandom_range(0, 99) < 85)
         put_random_fmt();
      if ($urandom_range(0, 9) == 0)
         put_random_fmt();
      case ($urandom_range(0, 3))
         0:       nbytes = $urandom_range(0, 4096);
         1:       nbytes = $urandom;
         2:       nbytes = 32'hFFFF_FFFF;
         default: nbytes = 32'd0;
      endcase
      put_data_head(nbytes);
      put_random($urandom_range(0, 5));
   endtask

   task automatic test_random_files();
      int start_bytes;
      int start_headers;
      int kind;
      int k;
      int i;
      start_bytes   = bytes_parsed;
      start_headers = headers_predicted;
      while (bytes_parsed - start_bytes < RANDOM_BYTES ||
             headers_predicted - start_headers < RANDOM_HEADERS) begin
         kind = $urandom_range(0, 99);
         if (kind < 60) begin
            build_random_wave();
            send_image(file_img.size(), 1'b1, $urandom_range(0, 1));
         end else if (kind < 82) begin
            // cut before the data header; the shorter part is left open
            build_random_wave();
            send_image($urandom_range(1, data_hdr_end - 1), 1'b1, kind < 75);
         end else if (kind < 92) begin
            // one bit flipped in the RIFF or WAVE tag
            build_random_wave();
            k = $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(8, 11);
            file_img[k] ^= 8'h01 << $urandom_range(0, 7);
            send_image(file_img.size(), 1'b1, $urandom_range(0, 1));
         end else begin
            // noise with stray marks
            file_img.delete();
            put_random($urandom_range(1, 12));
            for (i = 0; i < file_img.size(); i++)
               send_byte(file_img[i], i == 0 && $urandom_range(0, 1),
                         $urandom_range(0, 7) == 0);
         end
      end
   endtask

   initial begin
      clear_parse();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_no_restart_mark();
      test_tag_errors();
      test_fmt_extremes();
      test_chunk_walk();
      test_truncation();
      test_random_files();
      req_valid <= 1'b0;
      while (expected_headers.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   // Hang guard: far beyond the slowest legal run
   initial begin
      #(5_000_000);
      $display("end of test: mismatches");
      $finish;
   end

endmodule

// File: sim.f
rtl/whp_pkg.sv
rtl/whp_div.sv
rtl/whp_ctrl.sv
rtl/whp_dpath.sv
rtl/wav_header_parser.sv
test/wav_header_parser_test.sv
